@@ rtl/cils_pkg.sv @@
// Package for the C integer literal scanner: scanner states, type codes, result record, decode functions.
package cils_pkg;

  localparam int CountW = 8;

  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  typedef enum logic [21:0] {
    S_NORMAL     = 22'h000001,
    S_SLASH      = 22'h000002,
    S_BCOMMENT   = 22'h000004,
    S_STAR       = 22'h000008,
    S_LCOMMENT   = 22'h000010,
    S_STRING     = 22'h000020,
    S_STRING_ESC = 22'h000040,
    S_CHAR       = 22'h000080,
    S_CHAR_ESC   = 22'h000100,
    S_DEC        = 22'h000200,
    S_ZERO       = 22'h000400,
    S_OCT        = 22'h000800,
    S_HEX0       = 22'h001000,
    S_HEX        = 22'h002000,
    S_U          = 22'h004000,
    S_L          = 22'h008000,
    S_LL         = 22'h010000,
    S_LU         = 22'h020000,
    S_LLU        = 22'h040000,
    S_UL         = 22'h080000,
    S_ULL        = 22'h100000,
    S_WORD       = 22'h200000
  } state_t;

  typedef enum logic [2:0] {
    T_INT    = 3'd0,
    T_LONG   = 3'd1,
    T_LLONG  = 3'd2,
    T_UINT   = 3'd3,
    T_ULONG  = 3'd4,
    T_ULLONG = 3'd5,
    T_ERROR  = 3'd6
  } lit_type_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  literal_char;
    logic [2:0]  type_code;
    logic [7:0]  error_char;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic       col;
    logic       fin;
    lit_type_t  ftype;
    logic [7:0] ferr;
    state_t     nstate;
  } act_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

  function automatic logic is_alpha_us(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_US};
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_alpha_us(c) || is_digit(c);
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_l(logic [7:0] c);
    return c inside {8'h6C, 8'h4C};
  endfunction

  function automatic logic is_u(logic [7:0] c);
    return c inside {8'h75, 8'h55};
  endfunction

  function automatic state_t role_of(logic [7:0] c);
    state_t s;
    case (c)
      CH_DQ:    s = S_STRING;
      CH_SQ:    s = S_CHAR;
      CH_SLASH: s = S_SLASH;
      default:  s = S_NORMAL;
    endcase
    return s;
  endfunction

  function automatic act_t act_none(state_t s);
    act_t a;
    a.col    = 1'b0;
    a.fin    = 1'b0;
    a.ftype  = T_INT;
    a.ferr   = 8'h00;
    a.nstate = s;
    return a;
  endfunction

  function automatic act_t act_collect(state_t s);
    act_t a;
    a     = act_none(s);
    a.col = 1'b1;
    return a;
  endfunction

  function automatic act_t act_fail(logic [7:0] c);
    act_t a;
    a       = act_collect(S_WORD);
    a.fin   = 1'b1;
    a.ftype = T_ERROR;
    a.ferr  = c;
    return a;
  endfunction

  function automatic act_t act_end(logic [7:0] c, lit_type_t t);
    act_t a;
    a       = act_none(role_of(c));
    a.fin   = 1'b1;
    a.ftype = t;
    return a;
  endfunction

  function automatic act_t normal_byte(logic [7:0] c);
    act_t a;
    if (c == CH_SLASH || c == CH_DQ || c == CH_SQ) begin
      a = act_none(role_of(c));
    end else if (c == CH_ZERO) begin
      a = act_collect(S_ZERO);
    end else if (is_digit(c)) begin
      a = act_collect(S_DEC);
    end else if (is_alpha_us(c)) begin
      a = act_none(S_WORD);
    end else begin
      a = act_none(S_NORMAL);
    end
    return a;
  endfunction

  function automatic act_t number_byte(logic [7:0] c, logic digit_ok, state_t stay,
                                       logic hex_bad);
    act_t a;
    if (digit_ok) begin
      a = act_collect(stay);
    end else if (is_l(c)) begin
      a = act_collect(S_L);
    end else if (is_u(c)) begin
      a = act_collect(S_U);
    end else if (is_alpha_us(c) || c == CH_DOT || (hex_bad && is_hex(c))) begin
      a = act_fail(c);
    end else begin
      a = act_end(c, T_INT);
    end
    return a;
  endfunction

  function automatic act_t suffix_byte(logic [7:0] c, lit_type_t t, logic has_l,
                                       state_t next_l, logic has_u, state_t next_u);
    act_t a;
    if (has_l && is_l(c)) begin
      a = act_collect(next_l);
    end else if (has_u && is_u(c)) begin
      a = act_collect(next_u);
    end else if (is_word(c)) begin
      a = act_fail(c);
    end else begin
      a = act_end(c, t);
    end
    return a;
  endfunction

endpackage

@@ rtl/cils_scan.sv @@
// Scanner state and literal count registers with the per-byte decode into up to two results.
module cils_scan #(
  parameter int MAX_LITERAL_CHARS = 255
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [7:0]    text_byte,
  output logic [1:0]    n_res,
  output cils_pkg::res_t res0,
  output cils_pkg::res_t res1
);
  import cils_pkg::*;

  state_t              scan_state;
  state_t              scan_state_next;
  logic [CountW-1:0]   collected_count;
  logic [CountW-1:0]   collected_count_next;
  act_t                a;
  logic                emit_col;
  logic                emit_fin;
  res_t                col_res;
  res_t                fin_res;

  always_comb begin
    case (scan_state)
      S_SLASH: begin
        if (text_byte == CH_STAR) a = act_none(S_BCOMMENT);
        else if (text_byte == CH_SLASH) a = act_none(S_LCOMMENT);
        else a = normal_byte(text_byte);
      end
      S_BCOMMENT: a = act_none(text_byte == CH_STAR ? S_STAR : S_BCOMMENT);
      S_STAR: begin
        if (text_byte == CH_SLASH) a = act_none(S_NORMAL);
        else if (text_byte == CH_STAR) a = act_none(S_STAR);
        else a = act_none(S_BCOMMENT);
      end
      S_LCOMMENT: begin
        a = act_none((text_byte == CH_CR || text_byte == CH_LF) ? S_NORMAL : S_LCOMMENT);
      end
      S_STRING: begin
        if (text_byte == CH_DQ) a = act_none(S_NORMAL);
        else if (text_byte == CH_BSL) a = act_none(S_STRING_ESC);
        else a = act_none(S_STRING);
      end
      S_STRING_ESC: a = act_none(S_STRING);
      S_CHAR: begin
        if (text_byte == CH_SQ) a = act_none(S_NORMAL);
        else if (text_byte == CH_BSL) a = act_none(S_CHAR_ESC);
        else a = act_none(S_CHAR);
      end
      S_CHAR_ESC: a = act_none(S_CHAR);
      S_DEC: a = number_byte(text_byte, is_digit(text_byte), S_DEC, 1'b0);
      S_ZERO: begin
        if (text_byte == CH_LX || text_byte == CH_UX) a = act_collect(S_HEX0);
        else a = number_byte(text_byte, is_oct(text_byte), S_OCT, 1'b1);
      end
      S_OCT: a = number_byte(text_byte, is_oct(text_byte), S_OCT, 1'b1);
      S_HEX0: begin
        if (is_hex(text_byte)) begin
          a = act_collect(S_HEX);
        end else begin
          a       = act_none(role_of(text_byte));
          a.col   = (text_byte != CH_LF);
          a.fin   = 1'b1;
          a.ftype = T_ERROR;
          a.ferr  = text_byte;
        end
      end
      S_HEX: a = number_byte(text_byte, is_hex(text_byte), S_HEX, 1'b0);
      S_L:   a = suffix_byte(text_byte, T_LONG, 1'b1, S_LL, 1'b1, S_LU);
      S_LL:  a = suffix_byte(text_byte, T_LLONG, 1'b0, S_NORMAL, 1'b1, S_LLU);
      S_LU:  a = suffix_byte(text_byte, T_ULONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_LLU: a = suffix_byte(text_byte, T_ULLONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_U:   a = suffix_byte(text_byte, T_UINT, 1'b1, S_UL, 1'b0, S_NORMAL);
      S_UL:  a = suffix_byte(text_byte, T_ULONG, 1'b1, S_ULL, 1'b0, S_NORMAL);
      S_ULL: a = suffix_byte(text_byte, T_ULLONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_WORD: a = act_none(is_word(text_byte) ? S_WORD : role_of(text_byte));
      default: a = normal_byte(text_byte);
    endcase
  end

  always_comb begin
    emit_col = a.col && (collected_count < CountW'(MAX_LITERAL_CHARS));
    emit_fin = a.fin && (collected_count != '0 || emit_col);
    n_res    = 2'(emit_col) + 2'(emit_fin);

    col_res              = '0;
    col_res.literal_char = text_byte;
    col_res.last_of_run  = !emit_fin;

    fin_res             = '0;
    fin_res.item_kind   = 1'b1;
    fin_res.type_code   = a.ftype;
    fin_res.error_char  = a.ferr;
    fin_res.last_of_run = 1'b1;

    res0 = emit_col ? col_res : fin_res;
    res1 = fin_res;

    scan_state_next = a.nstate;
    if (a.fin) collected_count_next = '0;
    else collected_count_next = collected_count + CountW'(emit_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state      <= S_NORMAL;
      collected_count <= '0;
    end else if (go) begin
      scan_state      <= scan_state_next;
      collected_count <= collected_count_next;
    end
  end

endmodule

@@ rtl/cils_outbuf.sv @@
// Two-entry result register that serializes the results of one byte onto the output channel.
module cils_outbuf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [1:0]     n_res,
  input  cils_pkg::res_t res0,
  input  cils_pkg::res_t res1,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           can_load,
  output cils_pkg::res_t head
);
  import cils_pkg::*;

  res_t       slot0;
  res_t       slot1;
  logic [1:0] cnt;
  logic       out_xfer;

  assign out_valid = (cnt != 2'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign can_load  = (cnt == 2'd0) || (cnt == 2'd1 && out_xfer);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= n_res;
    end else if (out_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (out_xfer) begin
      slot0 <= slot1;
    end
  end

endmodule

@@ rtl/c_integer_literal_scanner.sv @@
// Top level of the C integer literal scanner: input register, scanner, result buffer.
//
//   channel  signals                                    direction
//   in       in_valid, in_stall, text_byte              byte in
//   out      out_valid, out_stall, item_kind,           result out
//            literal_char, type_code, error_char, last_of_run
//
// One byte per cycle unless the result buffer is busy, e.g. after two results.
// A byte passes through the input register, then the result register.
// Synchronous reset returns the scanner to normal text with an empty literal.
// A stalled output keeps its result; the input stalls while results cannot be loaded.
module c_integer_literal_scanner #(
  parameter int MAX_LITERAL_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       item_kind,
  output logic [7:0] literal_char,
  output logic [2:0] type_code,
  output logic [7:0] error_char,
  output logic       last_of_run
);
  import cils_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       go;
  logic       can_load;
  logic [1:0] n_res;
  res_t       res0;
  res_t       res1;
  res_t       head;

  assign go       = s1_valid && (n_res == 2'd0 || can_load);
  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_byte <= text_byte;
  end

  cils_scan #(
    .MAX_LITERAL_CHARS(MAX_LITERAL_CHARS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .text_byte (s1_byte),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1)
  );

  cils_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (go && n_res != 2'd0),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .head      (head)
  );

  assign item_kind    = head.item_kind;
  assign literal_char = head.literal_char;
  assign type_code    = head.type_code;
  assign error_char   = head.error_char;
  assign last_of_run  = head.last_of_run;

endmodule

@@ rtl/cils_checker.sv @@
// Port-level checker for the C integer literal scanner, bound to the top level.
module cils_props (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       item_kind,
  input logic [7:0] literal_char,
  input logic [2:0] type_code,
  input logic [7:0] error_char,
  input logic       last_of_run
);
  import cils_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(item_kind) && $stable(literal_char)
      && $stable(type_code) && $stable(error_char) && $stable(last_of_run))
    else $error("stalled result changed");

  a_char_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !item_kind |-> type_code == T_INT && error_char == 8'h00)
    else $error("literal byte carries type or error");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind |-> last_of_run && literal_char == 8'h00)
    else $error("terminator not last of run");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind && type_code != T_ERROR |-> error_char == 8'h00
      && type_code != 3'd7)
    else $error("bad terminator code");

endmodule

bind c_integer_literal_scanner cils_props u_cils_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .item_kind    (item_kind),
  .literal_char (literal_char),
  .type_code    (type_code),
  .error_char   (error_char),
  .last_of_run  (last_of_run)
);

@@ tb/cils_checker.sv @@
// Checker for the C integer literal scanner: predicts results of accepted bytes and compares.
`timescale 1ns / 1ps
module cils_checker #(
  parameter int MAX_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       item_kind,
  input  logic [7:0] literal_char,
  input  logic [2:0] type_code,
  input  logic [7:0] error_char,
  input  logic       last_of_run,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);
  import cils_pkg::*;

  state_t      scan_st;
  int unsigned lit_len;
  res_t        step_out [2];
  int          step_n;
  res_t        lex_results [$];
  int          mism;
  int          compared;

  function automatic logic is_dec_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oct_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic logic is_hex_digit(logic [7:0] c);
    return is_dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
  endfunction

  function automatic logic is_ident_char(logic [7:0] c);
    return is_ident_start(c) || is_dec_digit(c);
  endfunction

  function automatic logic is_l_suffix(logic [7:0] c);
    return c == "l" || c == "L";
  endfunction

  function automatic logic is_u_suffix(logic [7:0] c);
    return c == "u" || c == "U";
  endfunction

  function automatic state_t opener_state(logic [7:0] c);
    if (c == CH_DQ) return S_STRING;
    if (c == CH_SQ) return S_CHAR;
    if (c == CH_SLASH) return S_SLASH;
    return S_NORMAL;
  endfunction

  task automatic put_char(logic [7:0] c);
    res_t r;
    if (lit_len < MAX_CHARS) begin
      r              = '0;
      r.item_kind    = 1'b0;
      r.literal_char = c;
      step_out[step_n] = r;
      step_n++;
      lit_len++;
    end
  endtask

  task automatic put_end(lit_type_t t, logic [7:0] e);
    res_t r;
    if (lit_len > 0) begin
      r            = '0;
      r.item_kind  = 1'b1;
      r.type_code  = t;
      r.error_char = e;
      step_out[step_n] = r;
      step_n++;
      lit_len = 0;
    end
  endtask

  task automatic text_start(logic [7:0] c);
    if (c == CH_SLASH || c == CH_DQ || c == CH_SQ) begin
      scan_st = opener_state(c);
    end else if (c == CH_ZERO) begin
      put_char(c);
      scan_st = S_ZERO;
    end else if (is_dec_digit(c)) begin
      put_char(c);
      scan_st = S_DEC;
    end else if (is_ident_start(c)) begin
      scan_st = S_WORD;
    end else begin
      scan_st = S_NORMAL;
    end
  endtask

  task automatic bad_word(logic [7:0] c);
    put_char(c);
    put_end(T_ERROR, c);
    scan_st = S_WORD;
  endtask

  task automatic close_lit(logic [7:0] c, lit_type_t t);
    put_end(t, 8'h00);
    scan_st = opener_state(c);
  endtask

  task automatic num_body(logic [7:0] c, logic ok, state_t stay, logic hex_bad);
    if (ok) begin
      put_char(c);
      scan_st = stay;
    end else if (is_l_suffix(c)) begin
      put_char(c);
      scan_st = S_L;
    end else if (is_u_suffix(c)) begin
      put_char(c);
      scan_st = S_U;
    end else if (is_ident_start(c) || c == CH_DOT || (hex_bad && is_hex_digit(c))) begin
      bad_word(c);
    end else begin
      close_lit(c, T_INT);
    end
  endtask

  task automatic sfx_body(logic [7:0] c, lit_type_t t, logic has_l, state_t nl,
                          logic has_u, state_t nu);
    if (has_l && is_l_suffix(c)) begin
      put_char(c);
      scan_st = nl;
    end else if (has_u && is_u_suffix(c)) begin
      put_char(c);
      scan_st = nu;
    end else if (is_ident_char(c)) begin
      bad_word(c);
    end else begin
      close_lit(c, t);
    end
  endtask

  task automatic lex_byte(logic [7:0] c);
    step_n = 0;
    case (scan_st)
      S_SLASH: begin
        if (c == CH_STAR) scan_st = S_BCOMMENT;
        else if (c == CH_SLASH) scan_st = S_LCOMMENT;
        else text_start(c);
      end
      S_BCOMMENT: scan_st = (c == CH_STAR) ? S_STAR : S_BCOMMENT;
      S_STAR: begin
        if (c == CH_SLASH) scan_st = S_NORMAL;
        else if (c == CH_STAR) scan_st = S_STAR;
        else scan_st = S_BCOMMENT;
      end
      S_LCOMMENT: if (c == CH_CR || c == CH_LF) scan_st = S_NORMAL;
      S_STRING: begin
        if (c == CH_DQ) scan_st = S_NORMAL;
        else if (c == CH_BSL) scan_st = S_STRING_ESC;
      end
      S_STRING_ESC: scan_st = S_STRING;
      S_CHAR: begin
        if (c == CH_SQ) scan_st = S_NORMAL;
        else if (c == CH_BSL) scan_st = S_CHAR_ESC;
      end
      S_CHAR_ESC: scan_st = S_CHAR;
      S_DEC: num_body(c, is_dec_digit(c), S_DEC, 1'b0);
      S_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          put_char(c);
          scan_st = S_HEX0;
        end else begin
          num_body(c, is_oct_digit(c), S_OCT, 1'b1);
        end
      end
      S_OCT: num_body(c, is_oct_digit(c), S_OCT, 1'b1);
      S_HEX0: begin
        if (is_hex_digit(c)) begin
          put_char(c);
          scan_st = S_HEX;
        end else begin
          if (c != CH_LF) put_char(c);
          put_end(T_ERROR, c);
          scan_st = opener_state(c);
        end
      end
      S_HEX: num_body(c, is_hex_digit(c), S_HEX, 1'b0);
      S_L:   sfx_body(c, T_LONG, 1'b1, S_LL, 1'b1, S_LU);
      S_LL:  sfx_body(c, T_LLONG, 1'b0, S_NORMAL, 1'b1, S_LLU);
      S_LU:  sfx_body(c, T_ULONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_LLU: sfx_body(c, T_ULLONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_U:   sfx_body(c, T_UINT, 1'b1, S_UL, 1'b0, S_NORMAL);
      S_UL:  sfx_body(c, T_ULONG, 1'b1, S_ULL, 1'b0, S_NORMAL);
      S_ULL: sfx_body(c, T_ULLONG, 1'b0, S_NORMAL, 1'b0, S_NORMAL);
      S_WORD: if (!is_ident_char(c)) scan_st = opener_state(c);
      default: text_start(c);
    endcase
    if (step_n > 0) step_out[step_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) lex_results.push_back(step_out[i]);
  endtask

  task automatic check_result;
    res_t got;
    res_t want;
    got.item_kind    = item_kind;
    got.literal_char = literal_char;
    got.type_code    = type_code;
    got.error_char   = error_char;
    got.last_of_run  = last_of_run;
    compared++;
    if (lex_results.size() == 0) begin
      if (mism < 10)
        $display("Unexpected result: kind=%0d char=%02h type=%0d err=%02h last=%0d",
                 got.item_kind, got.literal_char, got.type_code, got.error_char,
                 got.last_of_run);
      mism++;
    end else begin
      want = lex_results.pop_front();
      if (got !== want) begin
        if (mism < 10)
          $display({"Mismatch: expected kind=%0d char=%02h type=%0d err=%02h last=%0d,",
                    " got kind=%0d char=%02h type=%0d err=%02h last=%0d"},
                   want.item_kind, want.literal_char, want.type_code, want.error_char,
                   want.last_of_run, got.item_kind, got.literal_char, got.type_code,
                   got.error_char, got.last_of_run);
        mism++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_st = S_NORMAL;
      lit_len = 0;
      lex_results.delete();
    end else begin
      if (in_valid && !in_stall) lex_byte(text_byte);
      if (out_valid && !out_stall) check_result();
    end
    fail_count   <= mism;
    pending      <= lex_results.size();
    results_seen <= compared;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the C integer literal scanner: reset, source text stimulus, stalls, verdict.
`timescale 1ns / 1ps
module tb;
  import cils_pkg::*;

  localparam int CycleLimit = 300000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] text_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       item_kind;
  logic [7:0] literal_char;
  logic [2:0] type_code;
  logic [7:0] error_char;
  logic       last_of_run;

  int         fail_count;
  int         pending;
  int         results_seen;
  int         send_idle_pct = 29;
  int         recv_idle_pct = 50;
  int         bytes_sent    = 0;
  int         phase_start;
  int         cycles        = 0;
  logic [7:0] text_q [$];

  c_integer_literal_scanner i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .literal_char (literal_char),
    .type_code    (type_code),
    .error_char   (error_char),
    .last_of_run  (last_of_run)
  );

  cils_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .literal_char (literal_char),
    .type_code    (type_code),
    .error_char   (error_char),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout with %0d results outstanding", pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic feed_text;
    while (text_q.size() > 0) push_byte(text_q.pop_front());
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_digit(int radix);
    int v;
    v = $urandom_range(radix - 1);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(v - 10);
  endfunction

  function automatic logic [7:0] word_char(logic first);
    int v;
    v = $urandom_range(first ? 52 : 62);
    if (v < 26) return 8'h61 + 8'(v);
    if (v < 52) return 8'h41 + 8'(v - 26);
    if (v < 62 && !first) return 8'h30 + 8'(v - 52);
    return CH_US;
  endfunction

  function automatic logic [7:0] pick_sep;
    case ($urandom_range(11))
      0, 1, 2: return " ";
      3:       return CH_LF;
      4:       return CH_CR;
      5:       return 8'h09;
      6:       return ";";
      7:       return ",";
      8:       return "+";
      9:       return ")";
      10:      return CH_SLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] bare_tail;
    case ($urandom_range(9))
      0:       return CH_LF;
      1:       return CH_DQ;
      2:       return CH_SQ;
      3:       return CH_SLASH;
      4:       return " ";
      5:       return "g";
      6:       return CH_DOT;
      7:       return CH_US;
      8:       return ";";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] bad_byte;
    case ($urandom_range(9))
      0:       return "g";
      1:       return "Z";
      2:       return CH_US;
      3:       return CH_DOT;
      4:       return "8";
      5:       return "9";
      6:       return "e";
      7:       return "x";
      8:       return "3";
      default: return word_char(1'b1);
    endcase
  endfunction

  task automatic add_suffix;
    case ($urandom_range(21))
      0:  add_str("u");
      1:  add_str("U");
      2:  add_str("l");
      3:  add_str("L");
      4:  add_str("ll");
      5:  add_str("LL");
      6:  add_str("ul");
      7:  add_str("Lu");
      8:  add_str("uLL");
      9:  add_str("llU");
      10: add_str("ULL");
      11: add_str("lu");
      12: add_str("lL");
      13: add_str("LLu");
      default: ;
    endcase
  endtask

  task automatic add_literal(input int form);
    int n;
    if (form == 0) begin
      text_q.push_back(8'h31 + 8'($urandom_range(8)));
      n = $urandom_range(5);
      repeat (n) text_q.push_back(pick_digit(10));
    end else if (form == 1) begin
      text_q.push_back(CH_ZERO);
      n = $urandom_range(4);
      repeat (n) text_q.push_back(pick_digit(8));
    end else begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(pick_digit(16));
    end
    add_suffix();
  endtask

  task automatic add_token;
    int         k;
    int         n;
    logic [7:0] c;
    k = $urandom_range(99);
    if (k < 25) begin
      add_literal(0);
    end else if (k < 35) begin
      add_literal(1);
    end else if (k < 50) begin
      add_literal(2);
    end else if (k < 55) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
      text_q.push_back(bare_tail());
    end else if (k < 65) begin
      add_literal($urandom_range(2));
      text_q.push_back(bad_byte());
      n = $urandom_range(3);
      repeat (n) text_q.push_back(word_char(1'b0));
    end else if (k < 72) begin
      text_q.push_back(word_char(1'b1));
      n = $urandom_range(6);
      repeat (n) text_q.push_back(word_char(1'b0));
    end else if (k < 78) begin
      add_str("/*");
      n = $urandom_range(8);
      repeat (n) begin
        case ($urandom_range(6))
          0, 1:    text_q.push_back(CH_STAR);
          2:       text_q.push_back(CH_SLASH);
          3:       text_q.push_back(pick_digit(10));
          4:       text_q.push_back(CH_LF);
          default: text_q.push_back(word_char(1'b1));
        endcase
      end
      if ($urandom_range(1)) add_str("*/");
      else add_str("**/");
    end else if (k < 83) begin
      add_str("//");
      n = $urandom_range(6);
      repeat (n) text_q.push_back($urandom_range(1) ? pick_digit(16) : 8'h20);
      text_q.push_back($urandom_range(1) ? CH_LF : CH_CR);
    end else if (k < 89) begin
      text_q.push_back(CH_DQ);
      n = $urandom_range(6);
      repeat (n) begin
        case ($urandom_range(4))
          0:       c = CH_BSL;
          1:       c = CH_SQ;
          2:       c = pick_digit(10);
          default: c = word_char(1'b1);
        endcase
        text_q.push_back(c);
        if (c == CH_BSL) text_q.push_back($urandom_range(1) ? CH_DQ : CH_BSL);
      end
      text_q.push_back(CH_DQ);
    end else if (k < 93) begin
      text_q.push_back(CH_SQ);
      if ($urandom_range(1)) begin
        text_q.push_back(CH_BSL);
        text_q.push_back($urandom_range(1) ? CH_SQ : "n");
      end else begin
        text_q.push_back($urandom_range(1) ? pick_digit(10) : CH_DQ);
      end
      text_q.push_back(CH_SQ);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(3) != 0) text_q.push_back(pick_sep());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, every type, bare hex prefix, literal ended by a slash
    text_q.push_back(8'hFF);
    add_str("0x''7/9u 0XfLU;1L 2ll 3ULL");
    text_q.push_back(8'h00);
    feed_text();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct =  29;
          recv_idle_pct <= 50;
        end
        1: begin
          send_idle_pct =  50;
          recv_idle_pct <= 29;
        end
        default: begin
          send_idle_pct =  0;
          recv_idle_pct <= 0;
          // over-length literal: bytes past the cap are dropped, terminator still comes
          text_q.push_back("1");
          repeat (259) text_q.push_back(pick_digit(10));
          add_str("ULL ");
          feed_text();
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 70) begin
        add_token();
        feed_text();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Scanned %0d source bytes: directed text, random token stream, long literal,",
             bytes_sent);
    $display("three sender/receiver stall profiles; %0d results compared", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cils_pkg.sv
rtl/cils_scan.sv
rtl/cils_outbuf.sv
rtl/c_integer_literal_scanner.sv
rtl/cils_checker.sv
tb/cils_checker.sv
tb/tb.sv
